### rtl/ofch_pkg.sv
package ofch_pkg;

   // Fixed widths of the transaction fields
   localparam int TIME_PORT_W  = 48;
   localparam int COUNT_PORT_W = 5;
   localparam int MODE_W       = 2;
   localparam int ERR_W        = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_RECEIVE  = 2'd0,
      MODE_ALLOCATE = 2'd1,
      MODE_PRUNE    = 2'd2
   } mode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK            = 3'd0,
      ERR_REPEAT        = 3'd1,
      ERR_LATE          = 3'd2,
      ERR_FULL          = 3'd3,
      ERR_BEFORE_OLDEST = 3'd4
   } err_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RECV_READ,
      ST_RECV_EVAL,
      ST_SCAN_FIRST,
      ST_SCAN,
      ST_COMMIT,
      ST_RESP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic init_wr;
      logic rd_last;
      logic recv_eval;
      logic scan_first;
      logic scan_step;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

### rtl/on_off_flow_control_history_top.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  mode, event_time, on_status
// rsp_      out        rsp_valid/rsp_stall  granted, grant_time, error_code, entry_count
//
// One transaction in flight at a time; each request gives exactly one response.
// Receive: the newest entry is read, then compared with the request, then the response.
// Allocate, prune: entries are scanned from the oldest (at most the number held), one
// entry per cycle through the single read port of the history RAM, then committed.
// Unused mode answers in the cycle after accept.
// Reset is synchronous; the cycle after reset writes the initial entry (time 0, on) with
// req_stall high. A stalled response holds its payload.
module on_off_flow_control_history_top #(
   parameter int HISTORY_DEPTH = 16,
   parameter int TIME_WIDTH    = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ofch_pkg::MODE_W-1:0]          req_mode,
   input  logic [ofch_pkg::TIME_PORT_W-1:0]     req_event_time,
   input  logic                                 req_on_status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_granted,
   output logic [ofch_pkg::TIME_PORT_W-1:0]     rsp_grant_time,
   output logic [ofch_pkg::ERR_W-1:0]           rsp_error_code,
   output logic [ofch_pkg::COUNT_PORT_W-1:0]    rsp_entry_count
);

   // command and status bundles between sequencer and datapath
   ofch_pkg::cmd_type cmd;
   ofch_pkg::sts_type sts;

   // sequencer: accepts a transaction in idle, steps the history read or scan,
   // commits the restamp after a scan, then holds the response until it is taken
   ofch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: history ring in RAM, oldest pointer, live count, window search
   // and the registered response fields
   ofch_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .TIME_WIDTH    (TIME_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_event_time  (req_event_time),
      .req_on_status   (req_on_status),
      .rsp_granted     (rsp_granted),
      .rsp_grant_time  (rsp_grant_time),
      .rsp_error_code  (rsp_error_code),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

### rtl/ofch_ram.sv
module ofch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ofch_datapath.sv
module ofch_datapath #(
   parameter int HISTORY_DEPTH = 16,
   parameter int TIME_WIDTH    = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ofch_pkg::cmd_type                    cmd,
   output ofch_pkg::sts_type                    sts,
   input  logic [ofch_pkg::MODE_W-1:0]          req_mode,
   input  logic [ofch_pkg::TIME_PORT_W-1:0]     req_event_time,
   input  logic                                 req_on_status,
   output logic                                 rsp_granted,
   output logic [ofch_pkg::TIME_PORT_W-1:0]     rsp_grant_time,
   output logic [ofch_pkg::ERR_W-1:0]           rsp_error_code,
   output logic [ofch_pkg::COUNT_PORT_W-1:0]    rsp_entry_count
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int ENT_W = TIME_WIDTH + 1;

   // ring position of the entry at offset off from the oldest
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(HISTORY_DEPTH)) begin
         sum = sum - SUM_W'(HISTORY_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [ofch_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [TIME_WIDTH-1:0]       t_ff, t_in;
   logic                        st_ff, st_in;
   logic [IDX_W-1:0]            oldest_ff, oldest_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            ri_ff, ri_in;
   logic [CNT_W-1:0]            rj_ff, rj_in;
   logic [TIME_WIDTH-1:0]       prev_time_ff, prev_time_in;
   logic                        prev_on_ff, prev_on_in;
   logic                        granted_ff, granted_in;
   logic [TIME_WIDTH-1:0]       gtime_ff, gtime_in;
   ofch_pkg::err_type           err_ff, err_in;
   logic                        fin_wr_ff, fin_wr_in;
   logic [CNT_W-1:0]            fin_idx_ff, fin_idx_in;
   logic [TIME_WIDTH-1:0]       fin_time_ff, fin_time_in;
   logic                        fin_on_ff, fin_on_in;

   logic                  wr_en, rd_en;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [ENT_W-1:0]      wr_data, rd_data;
   logic [TIME_WIDTH-1:0] cur_time;
   logic                  cur_on;
   logic [CNT_W-1:0]      count_m1, rj_m1;
   logic [IDX_W-1:0]      last_slot, fin_slot;
   logic                  is_last, has_prev, scan_done;

   // entry layout: {time, on}
   ofch_ram #(
      .WIDTH (ENT_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cur_time  = rd_data[ENT_W-1:1];
   assign cur_on    = rd_data[0];
   assign count_m1  = count_ff - 1'b1;
   assign rj_m1     = rj_ff - 1'b1;
   assign last_slot = slot_of(oldest_ff, count_m1);
   assign fin_slot  = slot_of(oldest_ff, fin_idx_ff);
   assign is_last   = (rj_ff == count_m1);
   assign has_prev  = (rj_ff != '0);

   always_comb begin
      mode_in      = mode_ff;
      t_in         = t_ff;
      st_in        = st_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      ri_in        = ri_ff;
      rj_in        = rj_ff;
      prev_time_in = prev_time_ff;
      prev_on_in   = prev_on_ff;
      granted_in   = granted_ff;
      gtime_in     = gtime_ff;
      err_in       = err_ff;
      fin_wr_in    = fin_wr_ff;
      fin_idx_in   = fin_idx_ff;
      fin_time_in  = fin_time_ff;
      fin_on_in    = fin_on_ff;
      wr_en        = 1'b0;
      wr_addr      = last_slot;
      wr_data      = {t_ff, st_ff};
      rd_en        = 1'b0;
      rd_addr      = slot_of(oldest_ff, ri_ff);
      scan_done    = 1'b0;

      if (cmd.init_wr) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = {{TIME_WIDTH{1'b0}}, 1'b1};
      end

      if (cmd.load) begin
         mode_in    = req_mode;
         t_in       = TIME_WIDTH'(req_event_time);
         st_in      = req_on_status;
         granted_in = 1'b0;
         gtime_in   = TIME_WIDTH'(req_event_time);
         err_in     = ofch_pkg::ERR_OK;
      end

      if (cmd.rd_last) begin
         rd_en   = 1'b1;
         rd_addr = last_slot;
      end

      // newest entry is on rd_data
      if (cmd.recv_eval) begin
         if (st_ff == cur_on) begin
            err_in = ofch_pkg::ERR_REPEAT;
         end else if (cur_time < t_ff) begin
            if (count_ff >= CNT_W'(HISTORY_DEPTH)) begin
               err_in = ofch_pkg::ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = slot_of(oldest_ff, count_ff);
               wr_data  = {t_ff, st_ff};
               count_in = count_ff + 1'b1;
            end
         end else if (count_ff == CNT_W'(1)) begin
            wr_en   = 1'b1;
            wr_addr = last_slot;
            wr_data = {cur_time, st_ff};
         end else begin
            err_in = ofch_pkg::ERR_LATE;
         end
      end

      if (cmd.scan_first) begin
         rd_en   = 1'b1;
         rd_addr = oldest_ff;
         ri_in   = CNT_W'(1);
         rj_in   = '0;
      end

      // entry rj is on rd_data, entry rj-1 sits in prev
      if (cmd.scan_step) begin
         rd_en        = 1'b1;
         ri_in        = ri_ff + 1'b1;
         rj_in        = rj_ff + 1'b1;
         prev_time_in = cur_time;
         prev_on_in   = cur_on;
         case (mode_ff)
            ofch_pkg::MODE_ALLOCATE: begin
               if (has_prev && prev_on_ff && (prev_time_ff >= t_ff)) begin
                  scan_done   = 1'b1;
                  granted_in  = 1'b1;
                  gtime_in    = prev_time_ff;
                  fin_wr_in   = 1'b1;
                  fin_idx_in  = rj_m1;
                  fin_time_in = prev_time_ff;
                  fin_on_in   = 1'b1;
               end else if (has_prev && prev_on_ff && (cur_time > t_ff)) begin
                  scan_done   = 1'b1;
                  granted_in  = 1'b1;
                  gtime_in    = t_ff;
                  fin_wr_in   = 1'b1;
                  fin_idx_in  = rj_m1;
                  fin_time_in = t_ff;
                  fin_on_in   = 1'b1;
               end else if (is_last) begin
                  scan_done = 1'b1;
                  fin_wr_in = cur_on;
                  if (cur_on) begin
                     granted_in  = 1'b1;
                     gtime_in    = (cur_time > t_ff) ? cur_time : t_ff;
                     fin_idx_in  = rj_ff;
                     fin_time_in = (cur_time > t_ff) ? cur_time : t_ff;
                     fin_on_in   = 1'b1;
                  end
               end
            end
            ofch_pkg::MODE_PRUNE: begin
               if (cur_time > t_ff) begin
                  scan_done = 1'b1;
                  if (!has_prev) begin
                     err_in    = ofch_pkg::ERR_BEFORE_OLDEST;
                     fin_wr_in = 1'b0;
                  end else begin
                     fin_wr_in   = 1'b1;
                     fin_idx_in  = rj_m1;
                     fin_time_in = t_ff;
                     fin_on_in   = prev_on_ff;
                  end
               end else if (is_last) begin
                  scan_done   = 1'b1;
                  fin_wr_in   = 1'b1;
                  fin_idx_in  = rj_ff;
                  fin_time_in = t_ff;
                  fin_on_in   = cur_on;
               end
            end
            default: begin
               scan_done = 1'b1;
               fin_wr_in = 1'b0;
            end
         endcase
      end

      // restamp the surviving entry and drop the ones before it
      if (cmd.commit && fin_wr_ff) begin
         wr_en     = 1'b1;
         wr_addr   = fin_slot;
         wr_data   = {fin_time_ff, fin_on_ff};
         oldest_in = fin_slot;
         count_in  = count_ff - fin_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff  <= '0;
         count_ff   <= CNT_W'(1);
         granted_ff <= 1'b0;
         err_ff     <= ofch_pkg::ERR_OK;
      end else begin
         oldest_ff  <= oldest_in;
         count_ff   <= count_in;
         granted_ff <= granted_in;
         err_ff     <= err_in;
      end
      mode_ff      <= mode_in;
      t_ff         <= t_in;
      st_ff        <= st_in;
      ri_ff        <= ri_in;
      rj_ff        <= rj_in;
      prev_time_ff <= prev_time_in;
      prev_on_ff   <= prev_on_in;
      gtime_ff     <= gtime_in;
      fin_wr_ff    <= fin_wr_in;
      fin_idx_ff   <= fin_idx_in;
      fin_time_ff  <= fin_time_in;
      fin_on_ff    <= fin_on_in;
   end

   assign sts.scan_done   = scan_done;
   assign rsp_granted     = granted_ff;
   assign rsp_grant_time  = ofch_pkg::TIME_PORT_W'(gtime_ff);
   assign rsp_error_code  = err_ff;
   assign rsp_entry_count = ofch_pkg::COUNT_PORT_W'(count_ff);

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_W'(HISTORY_DEPTH)))
      else $error("history count out of range");

   a_oldest_range : assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= IDX_W'(HISTORY_DEPTH - 1))
      else $error("oldest pointer beyond ring");

   a_grant_no_err : assert property (@(posedge clock) disable iff (reset)
      granted_ff |-> (err_ff == ofch_pkg::ERR_OK))
      else $error("grant flagged with an error");

   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      (!cmd.recv_eval && !cmd.commit) |=> $stable(count_ff))
      else $error("history count moved outside receive or commit");
`endif

endmodule

### rtl/ofch_ctrl.sv
module ofch_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [ofch_pkg::MODE_W-1:0] req_mode,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ofch_pkg::cmd_type           cmd,
   input  ofch_pkg::sts_type           sts
);

   ofch_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ofch_pkg::ST_INIT: begin
            state_in = ofch_pkg::ST_IDLE;
         end
         ofch_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  ofch_pkg::MODE_RECEIVE:  state_in = ofch_pkg::ST_RECV_READ;
                  ofch_pkg::MODE_ALLOCATE: state_in = ofch_pkg::ST_SCAN_FIRST;
                  ofch_pkg::MODE_PRUNE:    state_in = ofch_pkg::ST_SCAN_FIRST;
                  default:                 state_in = ofch_pkg::ST_RESP;
               endcase
            end
         end
         ofch_pkg::ST_RECV_READ: begin
            state_in = ofch_pkg::ST_RECV_EVAL;
         end
         ofch_pkg::ST_RECV_EVAL: begin
            state_in = ofch_pkg::ST_RESP;
         end
         ofch_pkg::ST_SCAN_FIRST: begin
            state_in = ofch_pkg::ST_SCAN;
         end
         ofch_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ofch_pkg::ST_COMMIT;
            end
         end
         ofch_pkg::ST_COMMIT: begin
            state_in = ofch_pkg::ST_RESP;
         end
         ofch_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ofch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ofch_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ofch_pkg::ST_INIT: begin
            cmd.init_wr = 1'b1;
         end
         ofch_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ofch_pkg::ST_RECV_READ: begin
            cmd.rd_last = 1'b1;
         end
         ofch_pkg::ST_RECV_EVAL: begin
            cmd.recv_eval = 1'b1;
         end
         ofch_pkg::ST_SCAN_FIRST: begin
            cmd.scan_first = 1'b1;
         end
         ofch_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ofch_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         ofch_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ofch_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### test/tb_on_off_flow_control_history_top.sv
module tb_on_off_flow_control_history_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DEPTH       = 16;
   localparam logic [1:0]  MODE_UNUSED = 2'd3;   // no operation, answers like a refused flit
   localparam logic [47:0] TIME_MAX    = '1;

   // One response transaction as it should come back
   typedef struct packed {
      logic                 granted;
      logic [47:0]          grant_time;
      ofch_pkg::err_type    error_code;
      logic [4:0]           entry_count;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = ofch_pkg::MODE_RECEIVE;
   logic [47:0] req_event_time = '0;
   logic        req_on_status = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_granted;
   logic [47:0] rsp_grant_time;
   logic [2:0]  rsp_error_code;
   logic [4:0]  rsp_entry_count;

   // Shadow copy of the on/off history ring, advanced at each accepted request
   logic [47:0] hist_time [DEPTH];
   logic        hist_on   [DEPTH];
   logic [3:0]  oldest_slot;
   logic [4:0]  held;

   outcome_type pending_outcomes[$];
   int          error_count = 0;
   int          sent_count  = 0;
   bit          req_idle_en = 1'b1;
   bit          rsp_idle_en = 1'b1;

   on_off_flow_control_history_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_event_time  (req_event_time),
      .req_on_status   (req_on_status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_granted     (rsp_granted),
      .rsp_grant_time  (rsp_grant_time),
      .rsp_error_code  (rsp_error_code),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // History predictor
   // ---------------------------------------------------------------------------

   // Ring position of the k-th live entry, counted from the oldest
   function automatic logic [3:0] ring(int k);
      return oldest_slot + k[3:0];
   endfunction

   function automatic logic [47:0] newest_time();
      return hist_time[ring(held - 1)];
   endfunction

   function automatic logic newest_on();
      return hist_on[ring(held - 1)];
   endfunction

   function automatic logic [47:0] oldest_time();
      return hist_time[oldest_slot];
   endfunction

   // Drop every entry at or before t; the last one dropped survives, re-stamped at t
   function automatic ofch_pkg::err_type trim_history(logic [47:0] t);
      int         k;
      logic [3:0] keep;
      k = 0;
      while (k < held && hist_time[ring(k)] <= t)
         k++;
      if (k == 0)
         return ofch_pkg::ERR_BEFORE_OLDEST;
      keep = ring(k - 1);
      oldest_slot = keep;
      hist_time[keep] = t;
      held = held - k[4:0] + 5'd1;
      return ofch_pkg::ERR_OK;
   endfunction

   function automatic outcome_type predict_outcome(logic [1:0] m, logic [47:0] t, logic s);
      outcome_type o;
      logic [3:0]  last;
      logic [47:0] et;
      o.granted    = 1'b0;
      o.grant_time = t;
      o.error_code = ofch_pkg::ERR_OK;
      last = ring(held - 1);
      case (m)
         ofch_pkg::MODE_RECEIVE: begin
            if (s == hist_on[last])
               o.error_code = ofch_pkg::ERR_REPEAT;
            else if (hist_time[last] < t) begin
               if (held >= DEPTH)
                  o.error_code = ofch_pkg::ERR_FULL;
               else begin
                  hist_time[ring(held)] = t;
                  hist_on[ring(held)]   = s;
                  held++;
               end
            end else if (held == 1)
               hist_on[last] = s;   // lone entry: status overwritten in place
            else
               o.error_code = ofch_pkg::ERR_LATE;
         end
         ofch_pkg::MODE_ALLOCATE: begin
            // first on-window that covers the flit, or the flit is pushed to its start
            for (int k = 0; k < held && !o.granted; k++) begin
               et = hist_time[ring(k)];
               if (hist_on[ring(k)]) begin
                  if (et >= t || k + 1 == held) begin
                     o.grant_time = (et > t) ? et : t;
                     o.granted    = 1'b1;
                  end else if (hist_time[ring(k + 1)] > t) begin
                     o.grant_time = t;
                     o.granted    = 1'b1;
                  end
               end
            end
            if (o.granted)
               o.error_code = trim_history(o.grant_time);
         end
         ofch_pkg::MODE_PRUNE: o.error_code = trim_history(t);
         default: ;
      endcase
      o.entry_count = held;
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: optional idle gap, then hold the transaction until accepted
   // ---------------------------------------------------------------------------
   task automatic send_request(logic [1:0] m, logic [47:0] t, logic s);
      outcome_type predicted;
      if (req_idle_en) begin
         while ($urandom_range(99) < 35) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_event_time <= t;
      req_on_status  <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = predict_outcome(m, t, s);
      pending_outcomes.insert(pending_outcomes.size(), predicted);
      sent_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random back-pressure and the scoreboard
   // ---------------------------------------------------------------------------
   always @(posedge clock)
      rsp_stall <= rsp_idle_en && ($urandom_range(99) < 35);

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            error_count++;
            $error("response transaction with none outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_granted !== want.granted) begin
               error_count++;
               $error("granted: expected %0d, actual %0d", want.granted, rsp_granted);
            end
            if (rsp_grant_time !== want.grant_time) begin
               error_count++;
               $error("grant_time: expected %0h, actual %0h", want.grant_time, rsp_grant_time);
            end
            if (rsp_error_code !== want.error_code) begin
               error_count++;
               $error("error_code: expected %0d, actual %0d", want.error_code, rsp_error_code);
            end
            if (rsp_entry_count !== want.entry_count) begin
               error_count++;
               $error("entry_count: expected %0d, actual %0d", want.entry_count,
                      rsp_entry_count);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Uniform time in [lo, hi]
   function automatic logic [47:0] pick_time(logic [47:0] lo, logic [47:0] hi);
      logic [63:0] r;
      r = {$urandom, $urandom};
      if (hi <= lo)
         return lo;
      return lo + 48'(r % (64'(hi - lo) + 64'd1));
   endfunction

   // Spacing between successive messages: mostly short, now and then a big jump
   function automatic logic [47:0] message_spacing();
      if ($urandom_range(99) < 2)
         return 48'($urandom) + 48'd1;
      return 48'($urandom_range(50, 1));
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Receive handling from the reset history (time 0, on), with allocate, unused and prune checks
   task automatic test_receive_cases();
      send_request(ofch_pkg::MODE_RECEIVE, 48'd0, 1'b1);     // repeated status
      send_request(ofch_pkg::MODE_RECEIVE, 48'd0, 1'b0);     // lone entry flipped to off
      send_request(ofch_pkg::MODE_ALLOCATE, 48'd5, 1'b0);    // nothing on: refused
      send_request(MODE_UNUSED, TIME_MAX, 1'b1);             // unused mode
      send_request(ofch_pkg::MODE_RECEIVE, 48'd0, 1'b1);     // lone entry back on
      send_request(ofch_pkg::MODE_RECEIVE, 48'd100, 1'b0);   // append
      send_request(ofch_pkg::MODE_RECEIVE, 48'd100, 1'b1);   // same time as newest: late
      send_request(ofch_pkg::MODE_RECEIVE, 48'd60, 1'b1);    // earlier than newest: late
      send_request(ofch_pkg::MODE_RECEIVE, 48'd200, 1'b1);   // append
      send_request(ofch_pkg::MODE_PRUNE, 48'd150, 1'b0);     // drops the oldest, off re-stamped at 150
      send_request(ofch_pkg::MODE_PRUNE, 48'd120, 1'b0);     // before oldest
   endtask

   // Fill the ring, then one more message bounces off
   task automatic test_history_full();
      while (held < DEPTH)
         send_request(ofch_pkg::MODE_RECEIVE, newest_time() + 48'd100, !newest_on());
      send_request(ofch_pkg::MODE_RECEIVE, newest_time() + 48'd100, !newest_on());
   endtask

   // Allocation inside a window, delayed to a window, past the end and refused; prunes between
   task automatic test_allocate_and_prune();
      send_request(ofch_pkg::MODE_ALLOCATE, 48'd250, 1'b0);  // inside the on-window at 200
      send_request(ofch_pkg::MODE_ALLOCATE, 48'd350, 1'b1);  // falls in off: pushed to 400
      send_request(ofch_pkg::MODE_PRUNE, oldest_time(), 1'b0);  // prune exactly at the oldest
      send_request(ofch_pkg::MODE_RECEIVE, newest_time() + 48'd100, 1'b0);
      send_request(ofch_pkg::MODE_ALLOCATE, 48'd5000, 1'b0); // newest is off: refused
      send_request(ofch_pkg::MODE_ALLOCATE, newest_time() - 48'd50, 1'b0);
      send_request(ofch_pkg::MODE_PRUNE, 48'd3000, 1'b1);
   endtask

   // Mostly well-formed message sequences with allocations and prunes in between,
   // plus a share of malformed requests
   task automatic test_random_traffic(int n);
      int          first;
      int          pick;
      int          burst;
      logic [47:0] lo;
      first = sent_count;
      while (sent_count - first < n) begin
         // a long quiet stretch with neither side idling
         req_idle_en = !((sent_count - first) >= n / 3 && (sent_count - first) < n / 3 + 300);
         rsp_idle_en = req_idle_en;
         pick = $urandom_range(99);
         if (pick < 40) begin
            burst = $urandom_range(8, 1);
            repeat (burst)
               send_request(ofch_pkg::MODE_RECEIVE, newest_time() + message_spacing(),
                            !newest_on());
         end else if (pick < 65) begin
            lo = (oldest_time() > 48'd40) ? oldest_time() - 48'd40 : 48'd0;
            send_request(ofch_pkg::MODE_ALLOCATE, pick_time(lo, newest_time() + 48'd60),
                         1'($urandom));
         end else if (pick < 80) begin
            send_request(ofch_pkg::MODE_PRUNE,
                         pick_time(oldest_time(), newest_time() + 48'd60), 1'($urandom));
         end else begin
            case ($urandom_range(3))
               0: send_request(ofch_pkg::MODE_RECEIVE, 48'({$urandom, $urandom}),
                               newest_on());
               1: send_request(ofch_pkg::MODE_RECEIVE, pick_time(48'd0, newest_time()),
                               !newest_on());
               2: send_request(ofch_pkg::MODE_PRUNE,
                               (oldest_time() == 48'd0) ? 48'd0
                                                        : pick_time(48'd0, oldest_time() - 48'd1),
                               1'($urandom));
               default: send_request(MODE_UNUSED, 48'({$urandom, $urandom}), 1'($urandom));
            endcase
         end
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   // Top of the time range; run last since times never go back down
   task automatic test_time_extremes();
      send_request(ofch_pkg::MODE_PRUNE, TIME_MAX, 1'b0);
      send_request(ofch_pkg::MODE_RECEIVE, 48'd0, !newest_on());
      send_request(ofch_pkg::MODE_RECEIVE, TIME_MAX, newest_on());
      if (newest_on())
         send_request(ofch_pkg::MODE_RECEIVE, 48'd0, 1'b0);
      send_request(ofch_pkg::MODE_ALLOCATE, 48'd0, 1'b0);    // lone off entry: refused
      send_request(ofch_pkg::MODE_RECEIVE, TIME_MAX, 1'b1);  // not later: overwrite to on
      send_request(ofch_pkg::MODE_ALLOCATE, 48'd0, 1'b1);    // delayed to the top of the range
      send_request(ofch_pkg::MODE_ALLOCATE, TIME_MAX, 1'b0);
      send_request(ofch_pkg::MODE_PRUNE, 48'd0, 1'b1);       // before oldest
      send_request(MODE_UNUSED, 48'd0, 1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         hist_time[i] = '0;
         hist_on[i]   = 1'b0;
      end
      hist_on[0]  = 1'b1;
      oldest_slot = '0;
      held        = 5'd1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_receive_cases();
      test_history_full();
      test_allocate_and_prune();
      test_random_traffic(1500);
      test_time_extremes();
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0)
         @(posedge clock);
      // wait beyond the longest scan for any stray response
      repeat (40) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
rtl/ofch_pkg.sv
rtl/ofch_ram.sv
rtl/ofch_datapath.sv
rtl/ofch_ctrl.sv
rtl/on_off_flow_control_history_top.sv
test/tb_on_off_flow_control_history_top.sv
